// ===== hw/rtl/cvft_pkg.sv =====
`timescale 1ns / 1ps

package cvft_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int MAX_OUT = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int MSG_W   = $clog2(MAX_OUT + 1);

   // stream widths
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   localparam logic [7:0] NO_VALUE = 8'hFF;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_FADE   = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_MSG   = 2'd1,
      KIND_REPLY = 2'd2
   } kind_type;

   // one stored fade entry
   typedef struct packed {
      logic [3:0]  channel;
      logic [6:0]  controller;
      logic [7:0]  current;
      logic [7:0]  goal;
      logic [15:0] rate;
      logic [15:0] count;
   } entry_type;

endpackage

// ===== hw/rtl/controller_value_fade_table.sv =====
`timescale 1ns / 1ps

// Controller value fade table. Holds up to ENTRIES fades, each keyed by a
// channel and controller number, in one single-port-write memory with a
// registered read; only the per-entry active bits live in flip-flops. Every
// request (tick, fade, cancel, query) walks the whole table once, one entry
// per cycle, with the read of the next entry overlapping the update of the
// current one. On a tick that emits several controller messages the walk
// pauses while the response register is still occupied. A tick returns one
// controller message per stepped entry (at most MAX_OUT, the last one
// flagged by rsp_tlast) or a single acknowledgement; fade and cancel return
// one acknowledgement, query one reply carrying the current value or 0xFF.
// rsp_tuser carries the result kind: 0 ack, 1 controller message, 2 reply.
// The next request is taken while the final result of the previous one is
// still waiting in the response register.

module controller_value_fade_table (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] channel, [10:4] cc, [18:11] target, [34:19] step_ticks,
   // [42:35] start_value, [47:43] zero
   input  logic [cvft_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [cvft_pkg::REQ_USER_W-1:0]   req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] msg_channel, [10:4] msg_cc, [18:11] value, [19] queue_full,
   // [23:20] zero
   output logic [cvft_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] kind
   output logic [cvft_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);

   import cvft_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 pv_ff, pv_in;
   logic [IDX_W-1:0]     p_idx_ff, p_idx_in;
   logic [ENTRIES-1:0]   slot_active_ff, slot_active_in;
   logic [MSG_W-1:0]     msg_cnt_ff, msg_cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // request latched for the walk
   func_type             op_func_ff, op_func_in;
   logic [3:0]           op_ch_ff, op_ch_in;
   logic [6:0]           op_cc_ff, op_cc_in;
   logic [7:0]           op_tgt_ff, op_tgt_in;
   logic [15:0]          op_rate_ff, op_rate_in;
   logic [7:0]           op_start_ff, op_start_in;

   // lookup result
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [7:0]           hit_cur_ff, hit_cur_in;

   // held controller message, sent once the next one or the walk end shows
   // whether it is the last
   logic [3:0]           pend_ch_ff, pend_ch_in;
   logic [6:0]           pend_cc_ff, pend_cc_in;
   logic [7:0]           pend_val_ff, pend_val_in;

   // response register
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [3:0]           rsp_ch_ff, rsp_ch_in;
   logic [6:0]           rsp_cc_ff, rsp_cc_in;
   logic [7:0]           rsp_val_ff, rsp_val_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_last_ff, rsp_last_in;

   // entry memory
   entry_type            mem [ENTRIES];
   entry_type            rd_q;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   entry_type            mem_wd;

   // walk datapath
   logic                 accept;
   logic                 out_free;
   logic                 is_tick;
   logic                 p_active;
   logic [15:0]          cnt_inc;
   logic                 at_goal;
   logic                 step_now;
   logic                 emit_now;
   logic                 stall;
   logic [7:0]           stepped;
   logic                 key_match;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // per-entry tick arithmetic on the entry just read
   assign is_tick   = (op_func_ff == FUNC_TICK);
   assign p_active  = slot_active_ff[p_idx_ff];
   assign cnt_inc   = rd_q.count + 16'd1;
   assign at_goal   = (rd_q.current == rd_q.goal);
   assign step_now  = pv_ff && is_tick && p_active && !at_goal && !(cnt_inc < rd_q.rate);
   assign emit_now  = step_now && (msg_cnt_ff < MSG_W'(MAX_OUT));
   assign stall     = emit_now && pend_valid_ff && !out_free;
   assign stepped   = (rd_q.current < rd_q.goal) ? rd_q.current + 8'd1
                                                 : rd_q.current - 8'd1;
   assign key_match = pv_ff && p_active && (rd_q.channel == op_ch_ff)
                      && (rd_q.controller == op_cc_ff);

   // lowest free entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!slot_active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      pv_in          = pv_ff;
      p_idx_in       = p_idx_ff;
      slot_active_in = slot_active_ff;
      msg_cnt_in     = msg_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_func_in     = op_func_ff;
      op_ch_in       = op_ch_ff;
      op_cc_in       = op_cc_ff;
      op_tgt_in      = op_tgt_ff;
      op_rate_in     = op_rate_ff;
      op_start_in    = op_start_ff;
      hit_idx_in     = hit_idx_ff;
      hit_cur_in     = hit_cur_ff;
      pend_ch_in     = pend_ch_ff;
      pend_cc_in     = pend_cc_ff;
      pend_val_in    = pend_val_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_ch_in      = rsp_ch_ff;
      rsp_cc_in      = rsp_cc_ff;
      rsp_val_in     = rsp_val_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      mem_we         = 1'b0;
      mem_wa         = p_idx_ff;
      mem_wd         = rd_q;

      // response taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_func_in    = func_type'(req_tuser[1:0]);
               op_ch_in      = req_tdata[3:0];
               op_cc_in      = req_tdata[10:4];
               op_tgt_in     = req_tdata[18:11];
               op_rate_in    = req_tdata[34:19];
               op_start_in   = req_tdata[42:35];
               msg_cnt_in    = '0;
               pend_valid_in = 1'b0;
               hit_in        = 1'b0;
               // first read goes out with the request
               rd_en         = 1'b1;
               rd_addr       = '0;
               rd_cnt_in     = CNT_W'(1);
               pv_in         = 1'b1;
               p_idx_in      = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               if (pv_ff && is_tick && p_active) begin
                  if (at_goal) begin
                     // fade finished, free the entry
                     slot_active_in[p_idx_ff] = 1'b0;
                  end else begin
                     mem_we = 1'b1;
                     if (step_now) begin
                        mem_wd.count   = '0;
                        mem_wd.current = stepped;
                     end else begin
                        mem_wd.count   = cnt_inc;
                     end
                  end
               end
               if (emit_now) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_MSG;
                     rsp_ch_in    = pend_ch_ff;
                     rsp_cc_in    = pend_cc_ff;
                     rsp_val_in   = pend_val_ff;
                     rsp_full_in  = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_ch_in    = rd_q.channel;
                  pend_cc_in    = rd_q.controller;
                  pend_val_in   = stepped;
                  msg_cnt_in    = msg_cnt_ff + MSG_W'(1);
               end
               // first matching active entry for fade, cancel and query
               if (!is_tick && key_match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = p_idx_ff;
                  hit_cur_in = rd_q.current;
               end
               if (rd_cnt_ff < CNT_W'(ENTRIES)) begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
                  pv_in     = 1'b1;
                  p_idx_in  = rd_cnt_ff[IDX_W-1:0];
               end else begin
                  pv_in    = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ACK;
               rsp_ch_in     = '0;
               rsp_cc_in     = '0;
               rsp_val_in    = '0;
               rsp_full_in   = 1'b0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               case (op_func_ff)
                  FUNC_TICK: begin
                     if (pend_valid_ff) begin
                        rsp_kind_in = KIND_MSG;
                        rsp_ch_in   = pend_ch_ff;
                        rsp_cc_in   = pend_cc_ff;
                        rsp_val_in  = pend_val_ff;
                     end
                  end
                  FUNC_FADE: begin
                     mem_wd.channel    = op_ch_ff;
                     mem_wd.controller = op_cc_ff;
                     mem_wd.goal       = op_tgt_ff;
                     mem_wd.rate       = op_rate_ff;
                     mem_wd.count      = '0;
                     if (hit_ff) begin
                        // refade keeps the present value
                        mem_we         = 1'b1;
                        mem_wa         = hit_idx_ff;
                        mem_wd.current = hit_cur_ff;
                     end else if (free_found) begin
                        mem_we         = 1'b1;
                        mem_wa         = free_idx;
                        mem_wd.current = (op_start_ff != NO_VALUE) ? op_start_ff : 8'd0;
                        slot_active_in[free_idx] = 1'b1;
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
                  FUNC_CANCEL: begin
                     if (hit_ff) begin
                        slot_active_in[hit_idx_ff] = 1'b0;
                     end
                  end
                  FUNC_QUERY: begin
                     rsp_kind_in = KIND_REPLY;
                     rsp_val_in  = hit_ff ? hit_cur_ff : NO_VALUE;
                  end
                  default: begin
                     rsp_kind_in = KIND_ACK;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_cnt_ff      <= '0;
         pv_ff          <= 1'b0;
         p_idx_ff       <= '0;
         slot_active_ff <= '0;
         msg_cnt_ff     <= '0;
         pend_valid_ff  <= 1'b0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_cnt_ff      <= rd_cnt_in;
         pv_ff          <= pv_in;
         p_idx_ff       <= p_idx_in;
         slot_active_ff <= slot_active_in;
         msg_cnt_ff     <= msg_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         hit_ff         <= hit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_func_ff  <= op_func_in;
      op_ch_ff    <= op_ch_in;
      op_cc_ff    <= op_cc_in;
      op_tgt_ff   <= op_tgt_in;
      op_rate_ff  <= op_rate_in;
      op_start_ff <= op_start_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cur_ff  <= hit_cur_in;
      pend_ch_ff  <= pend_ch_in;
      pend_cc_ff  <= pend_cc_in;
      pend_val_ff <= pend_val_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_cc_ff   <= rsp_cc_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_full_ff <= rsp_full_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_full_ff, rsp_val_ff, rsp_cc_ff, rsp_ch_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/fade_checker.sv =====
`timescale 1ns / 1ps

module fade_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [cvft_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [cvft_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [cvft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [cvft_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            rsp_tlast,
   output int                              fail_count,
   output int                              pending
);

   import cvft_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [3:0] channel;
      logic [6:0] controller;
      logic [7:0] value;
      logic       full;
      logic       last;
   } fade_result_type;

   // shadow of the fade table
   logic      fade_on [ENTRIES];
   entry_type fade_slot [ENTRIES];

   fade_result_type expected_results [$];
   int              mismatches = 0;

   assign fail_count = mismatches;

   task automatic report(input string msg);
      $display("%0t fade_checker: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic int find_fade(input logic [3:0] ch, input logic [6:0] cc);
      for (int i = 0; i < ENTRIES; i++)
         if (fade_on[i] && fade_slot[i].channel == ch && fade_slot[i].controller == cc)
            return i;
      return -1;
   endfunction

   function automatic fade_result_type make_result(input kind_type kind,
                                                   input logic [3:0] ch,
                                                   input logic [6:0] cc,
                                                   input logic [7:0] value,
                                                   input logic full, input logic last);
      fade_result_type r;
      r.kind       = kind;
      r.channel    = ch;
      r.controller = cc;
      r.value      = value;
      r.full       = full;
      r.last       = last;
      return r;
   endfunction

   // walk the table for a tick, or apply a fade, cancel or query
   task automatic apply_request(input func_type func, input logic [3:0] ch,
                                input logic [6:0] cc, input logic [7:0] goal,
                                input logic [15:0] rate, input logic [7:0] start);
      int              hit;
      int              open_idx;
      logic [15:0]     next_count;
      logic            full;
      fade_result_type step_msgs [$];
      hit      = find_fade(ch, cc);
      open_idx = -1;
      full     = 1'b0;
      case (func)
         FUNC_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (fade_on[i]) begin
                  if (fade_slot[i].current == fade_slot[i].goal) begin
                     fade_on[i] = 1'b0;
                  end else begin
                     next_count = fade_slot[i].count + 16'd1;
                     if (next_count < fade_slot[i].rate) begin
                        fade_slot[i].count = next_count;
                     end else begin
                        fade_slot[i].count = '0;
                        if (fade_slot[i].current < fade_slot[i].goal)
                           fade_slot[i].current = fade_slot[i].current + 8'd1;
                        else
                           fade_slot[i].current = fade_slot[i].current - 8'd1;
                        if (step_msgs.size() < MAX_OUT)
                           step_msgs.push_back(make_result(KIND_MSG, fade_slot[i].channel,
                                                           fade_slot[i].controller,
                                                           fade_slot[i].current, 1'b0, 1'b0));
                     end
                  end
               end
            end
            if (step_msgs.size() == 0) begin
               expected_results.push_back(make_result(KIND_ACK, '0, '0, '0, 1'b0, 1'b1));
            end else begin
               step_msgs[step_msgs.size()-1].last = 1'b1;
               foreach (step_msgs[i]) expected_results.push_back(step_msgs[i]);
            end
         end
         FUNC_FADE: begin
            if (hit >= 0) begin
               // refade keeps the present value
               fade_slot[hit].goal  = goal;
               fade_slot[hit].rate  = rate;
               fade_slot[hit].count = '0;
            end else begin
               for (int i = ENTRIES - 1; i >= 0; i--)
                  if (!fade_on[i]) open_idx = i;
               if (open_idx < 0) begin
                  full = 1'b1;
               end else begin
                  fade_on[open_idx]              = 1'b1;
                  fade_slot[open_idx].channel    = ch;
                  fade_slot[open_idx].controller = cc;
                  fade_slot[open_idx].current    = (start == NO_VALUE) ? 8'd0 : start;
                  fade_slot[open_idx].goal       = goal;
                  fade_slot[open_idx].rate       = rate;
                  fade_slot[open_idx].count      = '0;
               end
            end
            expected_results.push_back(make_result(KIND_ACK, '0, '0, '0, full, 1'b1));
         end
         FUNC_CANCEL: begin
            if (hit >= 0) fade_on[hit] = 1'b0;
            expected_results.push_back(make_result(KIND_ACK, '0, '0, '0, 1'b0, 1'b1));
         end
         default: begin
            expected_results.push_back(make_result(KIND_REPLY, '0, '0,
                                                   (hit >= 0) ? fade_slot[hit].current
                                                              : NO_VALUE,
                                                   1'b0, 1'b1));
         end
      endcase
   endtask

   task automatic check_response();
      fade_result_type want;
      if (expected_results.size() == 0) begin
         report($sformatf("result with none expected, tuser %0h tdata %h",
                          rsp_tuser, rsp_tdata));
      end else begin
         want = expected_results.pop_front();
         compare_field("kind", rsp_tuser, want.kind);
         compare_field("msg_channel", rsp_tdata[3:0], want.channel);
         compare_field("msg_cc", rsp_tdata[10:4], want.controller);
         compare_field("value", rsp_tdata[18:11], want.value);
         compare_field("queue_full", rsp_tdata[19], want.full);
         compare_field("last", rsp_tlast, want.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (fade_on[i]) fade_on[i] = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready)
            apply_request(func_type'(req_tuser), req_tdata[3:0], req_tdata[10:4],
                          req_tdata[18:11], req_tdata[34:19], req_tdata[42:35]);
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   import cvft_pkg::*;

   // cycles without any request or result moving before the run is called hung
   localparam int IDLE_LIMIT = 3000;
   // settle time after the last result, about two table walks
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 4;
   localparam int KEYS = 24;
   localparam int RANDOM_REQUESTS = 254;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [3:0] channel, [10:4] cc, [18:11] target, [34:19] step_ticks,
   // [42:35] start_value, [47:43] zero
   logic [REQ_DATA_W-1:0] req_tdata;
   // [1:0] func
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [3:0] msg_channel, [10:4] msg_cc, [18:11] value, [19] queue_full,
   // [23:20] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] kind
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   int fail_count;
   int pending;

   // pacing state; calm and long_hold are shared between stimulus and receiver
   bit calm = 1'b0;
   int long_hold = 0;
   int rsp_stall = 0;

   // pool of channel / controller pairs, wider than the table so it can fill
   logic [3:0] key_channel [KEYS];
   logic [6:0] key_cc [KEYS];

   controller_value_fade_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   fade_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // half back to back, often a short gap, now and then a long one; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm)    return 0;
      if (r < 50)  return 0;
      if (r < 90)  return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_tready <= 1'b0;
         long_hold--;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // hang detector: nothing moving on either stream for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: errors");
      $finish;
   end

   // one request; called at a falling edge, returns at the falling edge after
   // the handshake so the next request can follow without a gap
   task automatic send_request(input func_type func, input logic [3:0] ch,
                               input logic [6:0] cc, input logic [7:0] goal,
                               input logic [15:0] rate, input logic [7:0] start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= func;
      req_tdata  <= {5'd0, start, rate, goal, cc, ch};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // sender pause until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int          k;
      int          r;
      logic [7:0]  start;
      logic [7:0]  goal;
      logic [15:0] rate;
      func_type    func;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_TICK;
      rsp_tready = 1'b0;
      foreach (key_channel[i]) begin
         key_channel[i] = 4'($urandom);
         key_cc[i]      = 7'($urandom);
      end
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // query and cancel of pairs that were never faded
      send_request(FUNC_QUERY, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_CANCEL, 4'd15, 7'd127, 8'd0, 16'd0, 8'd0);
      // unknown start value begins at zero, zero rate steps every tick
      send_request(FUNC_FADE, 4'd0, 7'd0, 8'd2, 16'd0, NO_VALUE);
      // slowest rate, does not step before it is cancelled
      send_request(FUNC_FADE, 4'd15, 7'd127, 8'd0, 16'hFFFF, 8'd254);
      // steps up to the top value
      send_request(FUNC_FADE, 4'd3, 7'd5, 8'd255, 16'd1, 8'd254);
      // two messages, last on the second
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_QUERY, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      // refade keeps the value, start value ignored
      send_request(FUNC_FADE, 4'd0, 7'd0, 8'd0, 16'd0, 8'd77);
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      // entries at their goal are freed, quiet tick gives a bare ack
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_QUERY, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_QUERY, 4'd15, 7'd127, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_CANCEL, 4'd15, 7'd127, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_QUERY, 4'd15, 7'd127, 8'd0, 16'd0, 8'd0);
      // rate two: ack, message, then cancel mid fade
      send_request(FUNC_FADE, 4'd7, 7'd64, 8'd0, 16'd2, 8'd3);
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_CANCEL, 4'd7, 7'd64, 8'd0, 16'd0, 8'd0);
      send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);

      // ---- backpressure: full table and message flood ----
      wait_drained();
      @(posedge clock);
      long_hold = 300;
      @(negedge clock);
      for (int i = 0; i < ENTRIES; i++) begin
         start = 8'($urandom);
         send_request(FUNC_FADE, 4'(i), 7'(i * 7 + 1), start ^ 8'h80, 16'd0, start);
      end
      // no free entry left, dropped with queue_full
      send_request(FUNC_FADE, 4'd0, 7'd0, 8'd9, 16'd0, 8'd1);
      // every entry steps, sixteen messages per tick
      repeat (4) send_request(FUNC_TICK, 4'd0, 7'd0, 8'd0, 16'd0, 8'd0);
      wait_drained();
      for (int i = 0; i < ENTRIES; i++)
         send_request(FUNC_CANCEL, 4'(i), 7'(i * 7 + 1), 8'd0, 16'd0, 8'd0);

      // ---- random part ----
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         calm = (i >= 100 && i < 140);
         if (i % 60 == 59) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 15) begin
            // noise: every field random
            send_request(func_type'($urandom_range(0, 3)), 4'($urandom), 7'($urandom),
                         8'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            k = $urandom_range(0, KEYS - 1);
            r = $urandom_range(0, 99);
            if (r < 40)      func = FUNC_TICK;
            else if (r < 70) func = FUNC_FADE;
            else if (r < 80) func = FUNC_CANCEL;
            else             func = FUNC_QUERY;
            start = ($urandom_range(0, 9) == 0) ? NO_VALUE : 8'($urandom);
            // goals mostly near the start so fades finish and free entries
            if ($urandom_range(0, 3) == 0) goal = 8'($urandom);
            else goal = start + 8'($urandom_range(0, 8)) - 8'd4;
            r = $urandom_range(0, 99);
            if (r < 60)      rate = 16'($urandom_range(0, 3));
            else if (r < 90) rate = 16'($urandom_range(4, 20));
            else             rate = 16'($urandom);
            send_request(func, key_channel[k], key_cc[k], goal, rate, start);
         end
      end
      calm = 1'b0;

      // ---- wind down ----
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
